FILE: rtl/plp_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes of the phase latency profiler.
// Used by plp_stats, plp_readout and phase_latency_profiler_unit.
package plp_pkg;

	localparam int CNT_W = 64;

	// Event selector codes.
	localparam logic [2:0] FN_PUBLISH = 3'd0;
	localparam logic [2:0] FN_HOST    = 3'd1;
	localparam logic [2:0] FN_RESUME  = 3'd2;
	localparam logic [2:0] FN_DIRECT  = 3'd3;
	localparam logic [2:0] FN_READOUT = 3'd4;

	// Readout counter indices.
	localparam logic [3:0] CNT_ENABLED     = 4'd0;
	localparam logic [3:0] CNT_RENDEZVOUS  = 4'd1;
	localparam logic [3:0] CNT_QUEUE       = 4'd2;
	localparam logic [3:0] CNT_WAKE        = 4'd3;
	localparam logic [3:0] CNT_WORK        = 4'd4;
	localparam logic [3:0] CNT_COMPLETE    = 4'd5;
	localparam logic [3:0] CNT_OVERALL     = 4'd6;
	localparam logic [3:0] CNT_DIRECT      = 4'd7;
	localparam logic [3:0] CNT_DIRECT_WORK = 4'd8;
	localparam logic [3:0] CNT_WAKE_PEAK   = 4'd9;
	localparam logic [3:0] CNT_WORK_PEAK   = 4'd10;
	localparam logic [3:0] CNT_TOTAL_PEAK  = 4'd11;
	localparam logic [3:0] CNT_CLAMPS      = 4'd12;
	localparam logic [3:0] CNT_RESIDUAL    = 4'd13;

	typedef struct packed {
		logic [2:0]       func;
		logic [CNT_W-1:0] begin_stamp;
		logic [CNT_W-1:0] end_stamp;
		logic [CNT_W-1:0] direct_cycles;
	} evt_item_t;

	typedef struct packed {
		logic [3:0]       counter_index;
		logic [CNT_W-1:0] counter_value;
		logic             last_flag;
	} rpt_item_t;

	typedef struct packed {
		logic             enabled;
		logic [CNT_W-1:0] rendezvous;
		logic [CNT_W-1:0] queue_sum;
		logic [CNT_W-1:0] wake_sum;
		logic [CNT_W-1:0] work_sum;
		logic [CNT_W-1:0] complete_sum;
		logic [CNT_W-1:0] overall_sum;
		logic [CNT_W-1:0] direct_cnt;
		logic [CNT_W-1:0] direct_work;
		logic [CNT_W-1:0] wake_peak;
		logic [CNT_W-1:0] work_peak;
		logic [CNT_W-1:0] overall_peak;
		logic [CNT_W-1:0] clamps;
	} plp_stats_t;

endpackage

FILE: rtl/plp_stats.sv
`timescale 1ns / 1ps
// Statistics registers and the event update.
// Depends on plp_pkg for the event and statistics types.
module plp_stats #(
	parameter int STAMP_WIDTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                apply,
	input  plp_pkg::evt_item_t  item,
	output plp_pkg::plp_stats_t stats
);
	import plp_pkg::*;

	plp_stats_t             stats_q;
	plp_stats_t             stats_d;
	logic [STAMP_WIDTH-1:0] last_publish_q;
	logic [STAMP_WIDTH-1:0] last_finish_q;
	logic [STAMP_WIDTH-1:0] b;
	logic [STAMP_WIDTH-1:0] e;
	logic                   be_ok;
	logic                   pb_ok;
	logic                   fe_ok;
	logic [CNT_W-1:0]       iv_be;
	logic [CNT_W-1:0]       iv_pb;
	logic [CNT_W-1:0]       iv_fe;
	logic [1:0]             clamp_inc;

	assign b = item.begin_stamp[STAMP_WIDTH-1:0];
	assign e = item.end_stamp[STAMP_WIDTH-1:0];

	// Intervals are clamped at zero when the end stamp lies below the start.
	assign be_ok = e >= b;
	assign pb_ok = b >= last_publish_q;
	assign fe_ok = e >= last_finish_q;
	assign iv_be = be_ok ? CNT_W'(e - b) : '0;
	assign iv_pb = pb_ok ? CNT_W'(b - last_publish_q) : '0;
	assign iv_fe = fe_ok ? CNT_W'(e - last_finish_q) : '0;

	always_comb begin
		stats_d   = stats_q;
		clamp_inc = 2'd0;
		case (item.func)
			FN_PUBLISH: begin
				stats_d.queue_sum = stats_q.queue_sum + iv_be;
				clamp_inc         = {1'b0, !be_ok};
			end
			FN_HOST: begin
				stats_d.wake_sum = stats_q.wake_sum + iv_pb;
				stats_d.work_sum = stats_q.work_sum + iv_be;
				if (iv_pb > stats_q.wake_peak) begin
					stats_d.wake_peak = iv_pb;
				end
				if (iv_be > stats_q.work_peak) begin
					stats_d.work_peak = iv_be;
				end
				clamp_inc = 2'({1'b0, !pb_ok} + {1'b0, !be_ok});
			end
			FN_RESUME: begin
				stats_d.rendezvous   = stats_q.rendezvous + CNT_W'(1);
				stats_d.complete_sum = stats_q.complete_sum + iv_fe;
				stats_d.overall_sum  = stats_q.overall_sum + iv_be;
				if (iv_be > stats_q.overall_peak) begin
					stats_d.overall_peak = iv_be;
				end
				clamp_inc = 2'({1'b0, !fe_ok} + {1'b0, !be_ok});
			end
			FN_DIRECT: begin
				stats_d.direct_cnt  = stats_q.direct_cnt + CNT_W'(1);
				stats_d.direct_work = stats_q.direct_work + item.direct_cycles;
			end
			default: begin
			end
		endcase
		stats_d.enabled = 1'b1;
		stats_d.clamps  = stats_q.clamps + CNT_W'(clamp_inc);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stats_q        <= '0;
			last_publish_q <= '0;
			last_finish_q  <= '0;
		end else if (apply) begin
			stats_q <= stats_d;
			if (item.func == FN_PUBLISH) begin
				last_publish_q <= e;
				last_finish_q  <= '0;
			end else if (item.func == FN_HOST) begin
				last_finish_q <= e;
			end
		end
	end

	assign stats = stats_q;

endmodule

FILE: rtl/plp_readout.sv
`timescale 1ns / 1ps
// Readout sequencer: streams the fourteen counters through an output register.
// Depends on plp_pkg for the statistics and report types and the counter indices.
module plp_readout (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req,
	input  plp_pkg::plp_stats_t stats,
	output logic                done,
	output logic                rpt_valid,
	input  logic                rpt_ready,
	output plp_pkg::rpt_item_t  rpt_item
);
	import plp_pkg::*;

	logic [3:0]       idx_q;
	logic [CNT_W-1:0] named_q;
	logic             rpt_valid_q;
	rpt_item_t        rpt_q;
	logic             slot_free;
	logic             load;
	logic [CNT_W-1:0] val;

	assign slot_free = !rpt_valid_q || rpt_ready;
	assign load      = req && slot_free;
	assign done      = load && (idx_q == CNT_RESIDUAL);

	always_comb begin
		case (idx_q)
			CNT_ENABLED:     val = CNT_W'(stats.enabled);
			CNT_RENDEZVOUS:  val = stats.rendezvous;
			CNT_QUEUE:       val = stats.queue_sum;
			CNT_WAKE:        val = stats.wake_sum;
			CNT_WORK:        val = stats.work_sum;
			CNT_COMPLETE:    val = stats.complete_sum;
			CNT_OVERALL:     val = stats.overall_sum;
			CNT_DIRECT:      val = stats.direct_cnt;
			CNT_DIRECT_WORK: val = stats.direct_work;
			CNT_WAKE_PEAK:   val = stats.wake_peak;
			CNT_WORK_PEAK:   val = stats.work_peak;
			CNT_TOTAL_PEAK:  val = stats.overall_peak;
			CNT_CLAMPS:      val = stats.clamps;
			CNT_RESIDUAL: begin
				val = (stats.overall_sum > named_q) ? stats.overall_sum - named_q : '0;
			end
			default:         val = '0;
		endcase
	end

	// The four phase sums are gathered one per counter as they stream out,
	// so the residual needs only one compare and subtract at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= CNT_ENABLED;
			rpt_valid_q <= 1'b0;
		end else if (load) begin
			rpt_valid_q <= 1'b1;
			idx_q       <= (idx_q == CNT_RESIDUAL) ? CNT_ENABLED : 4'(idx_q + 4'd1);
		end else if (rpt_ready) begin
			rpt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rpt_q.counter_index <= idx_q;
			rpt_q.counter_value <= val;
			rpt_q.last_flag     <= (idx_q == CNT_RESIDUAL);
			if (idx_q == CNT_ENABLED) begin
				named_q <= '0;
			end else if (idx_q inside {[CNT_QUEUE:CNT_COMPLETE]}) begin
				named_q <= named_q + val;
			end
		end
	end

	assign rpt_valid = rpt_valid_q;
	assign rpt_item  = rpt_q;

endmodule

FILE: rtl/phase_latency_profiler_unit.sv
`timescale 1ns / 1ps
// Top level of the phase latency profiler: input register, statistics, readout.
// Depends on plp_pkg, plp_stats and plp_readout.
//
// Phase events enter an input register and update the statistics in the cycle
// after they are taken, one event per clock with no gaps unless a readout holds
// the channel: each is a few 64-bit subtract, add and compare paths between
// the input register and the counter registers. A readout event stays in the
// input register while the fourteen counters stream out through the output
// register, one per cycle unless the report side stalls, so it holds the event
// channel until the last counter is loaded. Counters seen by a readout include
// every event taken before it. Selector codes five to seven are dropped without
// effect. STAMP_WIDTH sets how many low bits of each stamp are used.
module phase_latency_profiler_unit #(
	parameter int STAMP_WIDTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               evt_valid,
	output logic               evt_ready,
	input  plp_pkg::evt_item_t evt_item,
	output logic               rpt_valid,
	input  logic               rpt_ready,
	output plp_pkg::rpt_item_t rpt_item
);
	import plp_pkg::*;

	logic       s1_valid_q;
	evt_item_t  item_s1;
	logic       s1_adv;
	logic       apply;
	logic       ro_req;
	logic       ro_done;
	plp_stats_t stats;

	assign ro_req    = s1_valid_q && (item_s1.func == FN_READOUT);
	assign apply     = s1_valid_q && (item_s1.func inside {[FN_PUBLISH:FN_DIRECT]});
	assign s1_adv    = s1_valid_q && (ro_req ? ro_done : 1'b1);
	assign evt_ready = !s1_valid_q || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (evt_ready) begin
			s1_valid_q <= evt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_ready && evt_valid) begin
			item_s1 <= evt_item;
		end
	end

	plp_stats #(
		.STAMP_WIDTH(STAMP_WIDTH)
	) u_stats (
		.clk   (clk),
		.arst_n(arst_n),
		.apply (apply),
		.item  (item_s1),
		.stats (stats)
	);

	plp_readout u_readout (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ro_req),
		.stats    (stats),
		.done     (ro_done),
		.rpt_valid(rpt_valid),
		.rpt_ready(rpt_ready),
		.rpt_item (rpt_item)
	);

	// Counters must not move while a readout is streaming them.
	a_stats_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		ro_req && !ro_done |=> $stable(stats))
		else $error("statistics changed during readout");

	a_evt_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		ro_req && !ro_done |-> !evt_ready)
		else $error("event channel open during readout");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid |-> (rpt_item.last_flag == (rpt_item.counter_index == CNT_RESIDUAL)))
		else $error("last flag does not match final counter index");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		ro_done |=> rpt_valid && rpt_item.last_flag)
		else $error("readout finished without final counter");

endmodule
